FILE: hdl/mbrtu_pkg.sv
package mbrtu_pkg;

    localparam int HDR_LEN = 11;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CRC     = 3'd1,
        ST_ADDR    = 3'd2,
        ST_ILLFN   = 3'd3,
        ST_LEN     = 3'd4,
        ST_WRFAIL  = 3'd5
    } status_t;

    localparam logic [7:0] FN_READ        = 8'd3;
    localparam logic [7:0] FN_WRITE       = 8'd16;
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FN = 8'd1;
    localparam logic [7:0] EXC_DEV_FAIL   = 8'd4;
    localparam logic [7:0] BROADCAST      = 8'd0;
    localparam logic [8:0] MIN_READ_LEN   = 9'd6;
    localparam logic [8:0] READ_REPLY_LEN = 9'd9;
    localparam logic [17:0] WRITE_OVERHEAD = 18'd7;

    localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] CFG_RESP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_LEN_EXC    = 2'd2;
    localparam logic [1:0] CFG_WR_MASK    = 2'd3;

    // Completed frame as the front end hands it to the back end
    typedef struct packed {
        logic [8:0]  len;
        logic        overflow;
        logic        crc_ok;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [7:0]  b5;
        logic [7:0]  b7;
        logic [7:0]  b8;
        logic [7:0]  b9;
        logic [7:0]  b10;
    } frame_t;

    // Bytewise Modbus CRC16 update, reflected polynomial 0xA001
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/mbrtu_ram.sv
module mbrtu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/mbrtu_front.sv
module mbrtu_front
    import mbrtu_pkg::*;
#(
    parameter int MAX_FRAME = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       fr_valid,
    output frame_t     fr_data
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [15:0]   crc_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [7:0]    hdr_reg [HDR_LEN];
    logic          take;
    logic [15:0]   crc_new;
    logic [CW-1:0] cnt_new;
    logic [7:0]    h [HDR_LEN];

    assign take    = (cnt_reg < CW'(MAX_FRAME));
    assign crc_new = take ? crc_byte(crc_reg, in_byte) : crc_reg;
    assign cnt_new = take ? cnt_reg + 1'b1 : cnt_reg;

    // Header bytes including the one arriving now
    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            h[i] = (take && cnt_reg == CW'(i)) ? in_byte : hdr_reg[i];
        end
    end

    // Accumulate, and restart at each frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= 16'hFFFF;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            fr_valid <= 1'b0;
        end else begin
            fr_valid <= in_valid && in_end;
            if (in_valid) begin
                for (int i = 0; i < HDR_LEN; i++) begin
                    hdr_reg[i] <= h[i];
                end
                if (in_end) begin
                    crc_reg <= 16'hFFFF;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    crc_reg <= crc_new;
                    cnt_reg <= cnt_new;
                    ovf_reg <= ovf_reg || !take;
                end
            end
        end
    end

    // Capture the finished frame summary
    always_ff @(posedge aclk) begin
        if (in_valid && in_end) begin
            fr_data.len      <= 9'(cnt_new);
            fr_data.overflow <= ovf_reg || !take;
            fr_data.crc_ok   <= (crc_new == 16'd0);
            fr_data.b0  <= h[0];
            fr_data.b1  <= h[1];
            fr_data.b2  <= h[2];
            fr_data.b3  <= h[3];
            fr_data.b4  <= h[4];
            fr_data.b5  <= h[5];
            fr_data.b7  <= h[7];
            fr_data.b8  <= h[8];
            fr_data.b9  <= h[9];
            fr_data.b10 <= h[10];
        end
    end

endmodule

FILE: hdl/mbrtu_fifo.sv
module mbrtu_fifo
    import mbrtu_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    input  frame_t wr_data,
    output logic   wr_room,
    output logic   rd_valid,
    input  logic   rd_ready,
    output frame_t rd_data
);

    localparam int DEPTH = 4;

    frame_t     q_reg [DEPTH];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = q_reg[rp_reg];
    assign pop      = rd_valid && rd_ready;

    // Room for one more frame end, counting the write already on its way
    assign wr_room  = ((cnt_reg + {2'd0, wr_valid}) < 3'd4);

    // Queue frame summaries between front and back end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_valid) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {2'd0, wr_valid} - {2'd0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            q_reg[wp_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/mbrtu_back.sv
module mbrtu_back
    import mbrtu_pkg::*;
#(
    parameter int REG_COUNT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fr_valid,
    output logic        fr_ready,
    input  frame_t      fr,
    input  logic [7:0]  slave_address,
    input  logic [8:0]  response_limit,
    input  logic [7:0]  len_exc_code,
    input  logic [63:0] wr_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte,
    output logic        m_txvalid,
    output logic        m_last,
    output logic [2:0]  m_status
);

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SEND} state_t;

    state_t      state_reg;
    logic [7:0]  rep_reg [9];
    logic [3:0]  len_reg;
    logic [3:0]  pos_reg;
    logic [2:0]  st_reg;
    logic        drop_reg;
    logic [15:0] crc_reg;
    logic [63:0] valid_reg;
    logic        ob_valid_reg;
    logic [7:0]  ob_byte_reg;
    logic        ob_txv_reg;
    logic        ob_last_reg;
    logic [2:0]  ob_st_reg;

    logic [14:0] idx;
    logic        in_range;
    logic [AW-1:0] ridx;
    logic [31:0] rdata;
    logic [31:0] rval;
    logic        ram_we;
    logic        addr_ok;
    logic [17:0] need16;
    logic        writable;
    logic        ob_free;
    logic        ob_load;
    logic [7:0]  cur;
    logic        is_last;

    assign idx      = {fr.b2, fr.b3[7:1]};
    assign in_range = (idx < 15'(REG_COUNT));
    assign ridx     = AW'(idx);
    assign addr_ok  = (fr.b0 == slave_address) || (fr.b0 == BROADCAST);
    assign need16   = {1'b0, fr.b4, fr.b5, 1'b0} + WRITE_OVERHEAD;
    assign writable = in_range && wr_mask[6'(ridx)];
    assign ob_free  = !ob_valid_reg || m_ready;
    assign ob_load  = (state_reg == S_SEND) && ob_free;
    assign fr_ready = (state_reg == S_IDLE);

    assign ram_we = fr_valid && fr_ready && !fr.overflow && fr.len >= 9'd2 && fr.crc_ok
                    && addr_ok && fr.b1 == FN_WRITE && {9'd0, fr.len} >= need16 && writable;

    mbrtu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_bank (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ridx),
        .wdata ({fr.b7, fr.b8, fr.b9, fr.b10}),
        .raddr (ridx),
        .rdata (rdata)
    );

    // Unwritten registers read as zero; the index was saved at classification
    assign rval = valid_reg[rep_reg[8][5:0]] ? rdata : 32'd0;

    assign cur     = (pos_reg == len_reg) ? crc_reg[7:0]
                   : (pos_reg == len_reg + 4'd1) ? crc_reg[15:8] : rep_reg[pos_reg];
    assign is_last = drop_reg || (pos_reg == len_reg + 4'd1);

    // Classify a frame, then stream its reply one byte per cycle unless m_ready stalls it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            ob_valid_reg <= 1'b0;
        end else begin
            if (ob_load) begin
                ob_valid_reg <= 1'b1;
            end else if (m_ready) begin
                ob_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (fr_valid) begin
                        if (ram_we) begin
                            valid_reg[6'(ridx)] <= 1'b1;
                        end
                        pos_reg  <= '0;
                        crc_reg  <= 16'hFFFF;
                        rep_reg[0] <= fr.b0;
                        rep_reg[8] <= {2'd0, 6'(ridx)};
                        if (fr.overflow) begin
                            drop_reg <= 1'b1; st_reg <= ST_LEN;
                            state_reg <= S_SEND;
                        end else if (fr.len < 9'd2 || !fr.crc_ok) begin
                            drop_reg <= 1'b1; st_reg <= ST_CRC;
                            state_reg <= S_SEND;
                        end else if (!addr_ok) begin
                            drop_reg <= 1'b1; st_reg <= ST_ADDR;
                            state_reg <= S_SEND;
                        end else if (fr.b1 == FN_READ) begin
                            drop_reg <= 1'b0;
                            if (fr.len < MIN_READ_LEN || response_limit < READ_REPLY_LEN) begin
                                st_reg <= ST_LEN; len_reg <= 4'd3;
                                rep_reg[1] <= FN_READ + EXC_FLAG;
                                rep_reg[2] <= len_exc_code;
                                state_reg  <= S_SEND;
                            end else begin
                                st_reg <= ST_OK; len_reg <= 4'd7;
                                rep_reg[1] <= FN_READ;
                                rep_reg[2] <= 8'd4;
                                state_reg  <= in_range ? S_READ : S_SEND;
                                if (!in_range) begin
                                    rep_reg[3] <= 8'd0; rep_reg[4] <= 8'd0;
                                    rep_reg[5] <= 8'd0; rep_reg[6] <= 8'd0;
                                end
                            end
                        end else if (fr.b1 == FN_WRITE) begin
                            drop_reg  <= 1'b0;
                            state_reg <= S_SEND;
                            if ({9'd0, fr.len} < need16) begin
                                st_reg <= ST_LEN; len_reg <= 4'd3;
                                rep_reg[1] <= FN_WRITE + EXC_FLAG;
                                rep_reg[2] <= len_exc_code;
                            end else if (!writable) begin
                                st_reg <= ST_WRFAIL; len_reg <= 4'd3;
                                rep_reg[1] <= FN_WRITE + EXC_FLAG;
                                rep_reg[2] <= EXC_DEV_FAIL;
                            end else begin
                                st_reg <= ST_OK; len_reg <= 4'd6;
                                rep_reg[1] <= FN_WRITE;
                                rep_reg[2] <= fr.b2; rep_reg[3] <= fr.b3;
                                rep_reg[4] <= fr.b4; rep_reg[5] <= fr.b5;
                            end
                        end else begin
                            drop_reg  <= 1'b0;
                            state_reg <= S_SEND;
                            st_reg <= ST_ILLFN; len_reg <= 4'd3;
                            rep_reg[1] <= fr.b1 | EXC_FLAG;
                            rep_reg[2] <= EXC_ILLEGAL_FN;
                        end
                    end
                end
                S_READ: begin
                    rep_reg[3] <= rval[31:24]; rep_reg[4] <= rval[23:16];
                    rep_reg[5] <= rval[15:8];  rep_reg[6] <= rval[7:0];
                    state_reg  <= S_SEND;
                end
                S_SEND: begin
                    if (ob_load) begin
                        ob_byte_reg  <= drop_reg ? 8'd0 : cur;
                        ob_txv_reg   <= !drop_reg;
                        ob_last_reg  <= is_last;
                        ob_st_reg    <= st_reg;
                        if (pos_reg < len_reg) begin
                            crc_reg <= crc_byte(crc_reg, cur);
                        end
                        pos_reg <= pos_reg + 4'd1;
                        if (is_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid   = ob_valid_reg;
    assign m_byte    = ob_byte_reg;
    assign m_txvalid = ob_txv_reg;
    assign m_last    = ob_last_reg;
    assign m_status  = ob_st_reg;

endmodule

FILE: hdl/modbus_rtu_slave_frame_engine.sv
// Modbus RTU slave: takes received frame bytes (tlast ends a frame) and emits the
// reply bytes with CRC appended, or one item with tx_valid low for a dropped frame.
// Input bytes are taken one per cycle while the frame-end queue (depth 4) has room;
// s_tready drops while four frame ends wait for the back end, or three with a fourth
// being written. Per frame the back end classifies the frame (and reads the register
// for a register read), then emits the result items: 1 item for a dropped frame, 5 to
// 9 reply bytes otherwise. A frame end passes the front end's frame register, the
// queue, the back end's classify state (and read state) and its output register.
// A low m_tready holds the output and stalls the back end, and s_tready once the queue fills.
module modbus_rtu_slave_frame_engine
    import mbrtu_pkg::*;
#(
    parameter int REG_COUNT = 64,
    parameter int MAX_FRAME = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte
    output logic [3:0]  m_tuser,   // tx_valid, status[2:0]
    output logic        m_tlast,   // tx_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [7:0]  slave_addr_reg;
    logic [8:0]  resp_limit_reg;
    logic [7:0]  len_exc_reg;
    logic [63:0] wr_mask_reg;
    logic        fr_valid, q_valid, q_ready, q_room, txv;
    frame_t      fr_data, q_data;
    logic [2:0]  st;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= 8'd1;
            resp_limit_reg <= 9'd256;
            len_exc_reg    <= 8'd3;
            wr_mask_reg    <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[7:0];
                CFG_RESP_LIMIT: resp_limit_reg <= cfg_data[8:0];
                CFG_LEN_EXC:    len_exc_reg    <= cfg_data[7:0];
                CFG_WR_MASK:    wr_mask_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = q_room;

    mbrtu_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .aclk, .aresetn,
        .in_valid (s_tvalid && s_tready), .in_byte (s_tdata), .in_end (s_tlast),
        .fr_valid, .fr_data
    );

    mbrtu_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid (fr_valid), .wr_data (fr_data), .wr_room (q_room),
        .rd_valid (q_valid), .rd_ready (q_ready), .rd_data (q_data)
    );

    mbrtu_back #(.REG_COUNT(REG_COUNT)) u_back (
        .aclk, .aresetn,
        .fr_valid (q_valid), .fr_ready (q_ready), .fr (q_data),
        .slave_address (slave_addr_reg), .response_limit (resp_limit_reg),
        .len_exc_code (len_exc_reg), .wr_mask (wr_mask_reg),
        .m_valid (m_tvalid), .m_ready (m_tready), .m_byte (m_tdata),
        .m_txvalid (txv), .m_last (m_tlast), .m_status (st)
    );

    assign m_tuser = {st, txv};

endmodule

FILE: hdl/mbrtu_checker.sv
module mbrtu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A dropped frame is one last item with zero data
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
        else $error("bad dropped-frame item");

    // Status stays in its defined range
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[3:1] <= 3'd5)
        else $error("status out of range");

endmodule

bind modbus_rtu_slave_frame_engine mbrtu_checker u_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
